[src/dlsq_pkg.sv]
// ----------------------------------------------------------------------------
// dlsq_pkg
// Shared types and codes for the delta-list sleep queue.
// ----------------------------------------------------------------------------
package dlsq_pkg;

    localparam int DELTA_W     = 32;   // tick count width
    localparam int ID_W        = 8;    // owner id width on the ports
    localparam int OWNER_MAX_W = 16;   // widest supported stored owner id

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_WAKE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [DELTA_W-1:0] sleep_ticks;
        logic [ID_W-1:0]    owner_id;
    } t_in;

    typedef struct packed {
        logic            kind;
        logic            status;
        logic [ID_W-1:0] woken_id;
        logic            last;
    } t_out;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IN_CHECK,
        S_IN_RD,
        S_IN_CMP,
        S_IN_DIFF,
        S_SH_RD,
        S_SH_WR,
        S_IN_WR,
        S_RESP,
        S_TK_HEAD,
        S_TK_RD_NEXT,
        S_TK_NEXT,
        S_TK_EMIT
    } t_state;

endpackage

[src/dlsq_alu.sv]
// ----------------------------------------------------------------------------
// dlsq_alu
// Shared 32-bit add/subtract unit with carry-out, used by every delta arithmetic step.
// ----------------------------------------------------------------------------
module dlsq_alu (
    input  logic [dlsq_pkg::DELTA_W-1:0] i_a,
    input  logic [dlsq_pkg::DELTA_W-1:0] i_b,
    input  dlsq_pkg::t_alu_op            i_op,
    output logic [dlsq_pkg::DELTA_W:0]   o_y
);
    import dlsq_pkg::*;

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_y = {1'b0, i_a} - {1'b0, i_b};
            default: o_y = '0;
        endcase
    end

endmodule

[src/dlsq_store.sv]
// ----------------------------------------------------------------------------
// dlsq_store
// Entry memory: delta and owner per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module dlsq_store #(
    parameter int CAPACITY    = 16,
    parameter int OWNER_WIDTH = 8,
    parameter int PTR_W       = 4
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [PTR_W-1:0]             i_waddr,
    input  logic [dlsq_pkg::DELTA_W-1:0] i_wdelta,
    input  logic [OWNER_WIDTH-1:0]       i_wowner,
    input  logic [PTR_W-1:0]             i_raddr,
    output logic [dlsq_pkg::DELTA_W-1:0] o_rdelta,
    output logic [OWNER_WIDTH-1:0]       o_rowner
);
    import dlsq_pkg::*;

    logic [DELTA_W-1:0]     r_mem_delta [CAPACITY];
    logic [OWNER_WIDTH-1:0] r_mem_owner [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_delta[i_waddr] <= i_wdelta;
            r_mem_owner[i_waddr] <= i_wowner;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdelta <= r_mem_delta[i_raddr];
        o_rowner <= r_mem_owner[i_raddr];
    end

endmodule

[src/delta_list_sleep_queue.sv]
// ----------------------------------------------------------------------------
// delta_list_sleep_queue
// Sorted sleep queue kept as a delta list in a circular entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one request:
//   cmd = insert (sleep_ticks, owner_id) or cmd = tick.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns results.
//   An insert always returns one acknowledgement (status ok or full).
//   A tick returns one expiry per leading entry that reaches zero, in queue
//   order, last set on the final one; a tick that frees nothing returns none.
// Sequencing:
//   One request at a time; o_in_ready is high only while the sequencer idles.
//   Insert: each entry scanned takes a memory read, then an add/compare in the
//   shared ALU; each entry moved toward the tail takes a read and a write.
//   Tick: the head is read and decremented; before each expiry is emitted the
//   entry after it, if there is one, is read to see whether it expires too.
//   The single read port of the entry memory sets this step order.
// Reset: synchronous, active low; empties the queue. Entry memory is not
//   cleared; only values from slots inside the live window are ever used.
// Stall: results sit in one output register; the sequencer waits in its
//   response or emit state while that register is full and not taken. A new
//   request is accepted while the last result still waits.
// ----------------------------------------------------------------------------
module delta_list_sleep_queue #(
    parameter int CAPACITY    = 16,
    parameter int OWNER_WIDTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dlsq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dlsq_pkg::t_out o_out_data
);
    import dlsq_pkg::*;

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // circular pointer helpers
    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] f_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
    endfunction

    t_state r_state, n_state;

    // queue window: live entries are head .. tail-1 (circular)
    logic [PTR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_count;

    // insert working registers
    logic [DELTA_W-1:0]     r_req;     // requested ticks, zero forced to one
    logic [OWNER_WIDTH-1:0] r_owner;
    logic [DELTA_W-1:0]     r_acc;     // deadline of entries passed so far
    logic [DELTA_W-1:0]     r_dnew;    // delta of the new entry
    logic [PTR_W-1:0]       r_ptr;     // scan pointer
    logic [PTR_W-1:0]       r_pos;     // slot of the new entry
    logic [PTR_W-1:0]       r_wptr;    // shift pointer, walks tail -> pos
    logic                   r_full;

    // tick working registers
    logic [OWNER_WIDTH-1:0] r_wake_owner;
    logic [OWNER_WIDTH-1:0] r_next_owner;
    logic                   r_more;    // entry after the expiring one expires too

    // output register
    logic r_out_valid;
    t_out r_out;

    // memory and ALU hookup
    logic                   mem_we;
    logic [PTR_W-1:0]       mem_waddr, mem_raddr;
    logic [DELTA_W-1:0]     mem_wdelta, rd_delta;
    logic [OWNER_WIDTH-1:0] mem_wowner, rd_owner;
    logic [DELTA_W-1:0]     alu_a, alu_b;
    t_alu_op                alu_op;
    logic [DELTA_W:0]       alu_y;

    logic                   in_fire, slot_free, out_load;
    t_out                   out_next;
    logic [DELTA_W-1:0]     head_dec;   // head delta after the tick, saturating
    logic                   scan_hit;
    logic [OWNER_MAX_W-1:0] owner_in_ext, wake_ext;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_fire      = i_in_valid && o_in_ready;
    assign slot_free    = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    assign owner_in_ext = OWNER_MAX_W'(i_in_data.owner_id);
    assign wake_ext     = OWNER_MAX_W'(r_wake_owner);
    assign head_dec     = (rd_delta == '0) ? '0 : alu_y[DELTA_W-1:0];
    assign scan_hit     = (alu_y >= {1'b0, r_req});

    dlsq_store #(
        .CAPACITY    (CAPACITY),
        .OWNER_WIDTH (OWNER_WIDTH),
        .PTR_W       (PTR_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdelta (mem_wdelta),
        .i_wowner (mem_wowner),
        .i_raddr  (mem_raddr),
        .o_rdelta (rd_delta),
        .o_rowner (rd_owner)
    );

    dlsq_alu u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_op (alu_op),
        .o_y  (alu_y)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.cmd == CMD_INSERT) begin
                        n_state = S_IN_CHECK;
                    end else if (r_count != '0) begin
                        n_state = S_TK_HEAD;
                    end
                end
            end
            S_IN_CHECK: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    n_state = S_RESP;
                end else if (r_count == '0) begin
                    n_state = S_IN_DIFF;
                end else begin
                    n_state = S_IN_RD;
                end
            end
            S_IN_RD: n_state = S_IN_CMP;
            S_IN_CMP: begin
                if (scan_hit || f_inc(r_ptr) == r_tail) begin
                    n_state = S_IN_DIFF;
                end else begin
                    n_state = S_IN_RD;
                end
            end
            S_IN_DIFF: n_state = S_SH_RD;
            S_SH_RD: n_state = (r_wptr == r_pos) ? S_IN_WR : S_SH_WR;
            S_SH_WR: n_state = S_SH_RD;
            S_IN_WR: n_state = S_RESP;
            S_RESP: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TK_HEAD: begin
                if (head_dec != '0) begin
                    n_state = S_IDLE;
                end else if (r_count == CNT_W'(1)) begin
                    n_state = S_TK_EMIT;
                end else begin
                    n_state = S_TK_RD_NEXT;
                end
            end
            S_TK_RD_NEXT: n_state = S_TK_NEXT;
            S_TK_NEXT: n_state = S_TK_EMIT;
            S_TK_EMIT: begin
                if (slot_free) begin
                    if (!r_more) begin
                        n_state = S_IDLE;
                    end else if (r_count == CNT_W'(2)) begin
                        n_state = S_TK_EMIT;
                    end else begin
                        n_state = S_TK_RD_NEXT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath control ----------------
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdelta = r_dnew;
        mem_wowner = r_owner;
        mem_raddr  = r_head;
        alu_a      = r_acc;
        alu_b      = rd_delta;
        alu_op     = ALU_ADD;
        out_load   = 1'b0;
        out_next   = '0;
        unique case (r_state)
            S_IN_RD: mem_raddr = r_ptr;
            S_IN_CMP: begin
                // acc + delta against the request
                alu_a  = r_acc;
                alu_b  = rd_delta;
                alu_op = ALU_ADD;
            end
            S_IN_DIFF: begin
                alu_a  = r_req;
                alu_b  = r_acc;
                alu_op = ALU_SUB;
            end
            S_SH_RD: mem_raddr = f_dec(r_wptr);
            S_SH_WR: begin
                // move one entry up; the follower of the new entry has the new delta taken off its own
                alu_a      = rd_delta;
                alu_b      = r_dnew;
                alu_op     = ALU_SUB;
                mem_we     = 1'b1;
                mem_waddr  = r_wptr;
                mem_wdelta = (f_dec(r_wptr) == r_pos) ? alu_y[DELTA_W-1:0] : rd_delta;
                mem_wowner = rd_owner;
            end
            S_IN_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_pos;
                mem_wdelta = r_dnew;
                mem_wowner = r_owner;
            end
            S_RESP: begin
                out_load        = slot_free;
                out_next.kind   = KIND_ACK;
                out_next.status = r_full;
                out_next.last   = 1'b1;
            end
            S_TK_HEAD: begin
                alu_a      = rd_delta;
                alu_b      = DELTA_W'(1);
                alu_op     = ALU_SUB;
                mem_we     = (head_dec != '0);
                mem_waddr  = r_head;
                mem_wdelta = head_dec;
                mem_wowner = rd_owner;
            end
            S_TK_RD_NEXT: mem_raddr = f_inc(r_head);
            S_TK_EMIT: begin
                out_load          = slot_free;
                out_next.kind     = KIND_WAKE;
                out_next.status   = STATUS_OK;
                out_next.woken_id = wake_ext[ID_W-1:0];
                out_next.last     = !r_more;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IN_WR) begin
                r_count <= r_count + 1'b1;
                r_tail  <= f_inc(r_tail);
            end
            if (r_state == S_TK_EMIT && slot_free) begin
                r_count <= r_count - 1'b1;
                r_head  <= f_inc(r_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_next;
        end
        unique case (r_state)
            S_IDLE: begin
                r_req   <= (i_in_data.sleep_ticks == '0) ? DELTA_W'(1)
                                                         : i_in_data.sleep_ticks;
                r_owner <= owner_in_ext[OWNER_WIDTH-1:0];
            end
            S_IN_CHECK: begin
                r_full <= (r_count == CNT_W'(CAPACITY)) ? STATUS_FULL : STATUS_OK;
                r_acc  <= '0;
                r_ptr  <= r_head;
                r_pos  <= r_tail;
            end
            S_IN_CMP: begin
                if (scan_hit) begin
                    r_pos <= r_ptr;
                end else begin
                    r_acc <= alu_y[DELTA_W-1:0];
                    r_ptr <= f_inc(r_ptr);
                    r_pos <= r_tail;
                end
            end
            S_IN_DIFF: begin
                r_dnew <= alu_y[DELTA_W-1:0];
                r_wptr <= r_tail;
            end
            S_SH_WR: r_wptr <= f_dec(r_wptr);
            S_TK_HEAD: begin
                r_wake_owner <= rd_owner;
                r_more       <= 1'b0;
            end
            S_TK_NEXT: begin
                r_more       <= (rd_delta == '0);
                r_next_owner <= rd_owner;
            end
            S_TK_EMIT: begin
                if (slot_free && r_more) begin
                    r_wake_owner <= r_next_owner;
                    if (r_count == CNT_W'(2)) begin
                        r_more <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

[src/dlsq_checker.sv]
// ----------------------------------------------------------------------------
// dlsq_checker
// Port-level checks for the sleep queue, bound to the top level.
// ----------------------------------------------------------------------------
module dlsq_props (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input dlsq_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input dlsq_pkg::t_out o_out_data
);
    import dlsq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // acknowledgements are single, closing results with no owner
    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_ACK |->
            o_out_data.last && o_out_data.woken_id == '0)
        else $error("malformed insert acknowledgement");

    // expiries never report full
    a_wake_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_WAKE |-> o_out_data.status == STATUS_OK)
        else $error("expiry with nonzero status");

    // ready drops right after an insert is accepted
    a_insert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.cmd == CMD_INSERT |=> !o_in_ready)
        else $error("ready right after an insert");

endmodule

bind delta_list_sleep_queue dlsq_props u_dlsq_props (.*);

[bench/dlsq_checker.sv]
// ----------------------------------------------------------------------------
// dlsq_checker
// Watches both channels of the sleep queue, keeps a shadow delta list and
// checks every result against the answers that list says are due.
// ----------------------------------------------------------------------------
module dlsq_checker #(
    parameter int CAPACITY    = 16,
    parameter int OWNER_WIDTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  dlsq_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  dlsq_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_ack_count,
    output int             o_full_count,
    output int             o_wake_count
);
    import dlsq_pkg::*;

    // shadow delta list
    logic [DELTA_W-1:0] sleep_delta [CAPACITY];
    logic [ID_W-1:0]    sleep_owner [CAPACITY];
    int                 sleep_depth = 0;

    t_out due_answers[$];
    int   fails = 0;
    int   acks  = 0;
    int   fulls = 0;
    int   wakes = 0;

    task automatic sleep_insert(input logic [DELTA_W-1:0] ticks,
                                input logic [ID_W-1:0]    owner);
        logic [63:0]        want;
        logic [63:0]        reached;
        logic [DELTA_W-1:0] gap;
        logic [ID_W-1:0]    kept;
        int                 pos;
        t_out               ans;
        ans.kind     = KIND_ACK;
        ans.status   = STATUS_OK;
        ans.woken_id = '0;
        ans.last     = 1'b1;
        if (sleep_depth >= CAPACITY) begin
            ans.status = STATUS_FULL;
            due_answers.push_back(ans);
            return;
        end
        // zero ticks sleeps until the next tick
        want    = (ticks == '0) ? 64'd1 : {32'd0, ticks};
        reached = '0;
        pos     = sleep_depth;
        for (int k = 0; k < sleep_depth; k++) begin
            if (reached + sleep_delta[k] >= want) begin
                pos = k;
                break;
            end
            reached += sleep_delta[k];
        end
        gap  = want[DELTA_W-1:0] - reached[DELTA_W-1:0];
        kept = owner;
        for (int b = OWNER_WIDTH; b < ID_W; b++)
            kept[b] = 1'b0;
        for (int k = sleep_depth; k > pos; k--) begin
            sleep_delta[k] = sleep_delta[k-1];
            sleep_owner[k] = sleep_owner[k-1];
        end
        sleep_delta[pos] = gap;
        sleep_owner[pos] = kept;
        sleep_depth++;
        if (pos + 1 < sleep_depth)
            sleep_delta[pos+1] -= gap;
        due_answers.push_back(ans);
    endtask

    task automatic sleep_tick();
        t_out ans;
        if (sleep_depth == 0)
            return;
        if (sleep_delta[0] != '0)
            sleep_delta[0] -= 1;
        while (sleep_depth > 0 && sleep_delta[0] == '0) begin
            ans.kind     = KIND_WAKE;
            ans.status   = STATUS_OK;
            ans.woken_id = sleep_owner[0];
            // next head expires too only if its delta is already zero
            ans.last     = (sleep_depth == 1) || (sleep_delta[1] != '0);
            due_answers.push_back(ans);
            for (int k = 1; k < sleep_depth; k++) begin
                sleep_delta[k-1] = sleep_delta[k];
                sleep_owner[k-1] = sleep_owner[k];
            end
            sleep_depth--;
        end
    endtask

    task automatic check_answer(input t_out got);
        t_out want;
        if (due_answers.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("[%0t] unexpected result: kind=%0b status=%0b id=%0h last=%0b",
                         $time, got.kind, got.status, got.woken_id, got.last);
            return;
        end
        want = due_answers.pop_front();
        if (got.kind == KIND_ACK) begin
            acks++;
            if (got.status == STATUS_FULL)
                fulls++;
        end else begin
            wakes++;
        end
        if (got.kind !== want.kind || got.status !== want.status ||
            got.woken_id !== want.woken_id || got.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
                $display("[%0t] result mismatch: expected kind=%0b status=%0b id=%0h last=%0b",
                         $time, want.kind, want.status, want.woken_id, want.last);
                $display("[%0t]                  got      kind=%0b status=%0b id=%0h last=%0b",
                         $time, got.kind, got.status, got.woken_id, got.last);
            end
        end
    endtask

    // results first: a result at the same edge belongs to an older request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sleep_depth = 0;
            due_answers.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_answer(i_out_data);
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.cmd == CMD_INSERT)
                    sleep_insert(i_in_data.sleep_ticks, i_in_data.owner_id);
                else
                    sleep_tick();
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_answers.size();
        o_ack_count  <= acks;
        o_full_count <= fulls;
        o_wake_count <= wakes;
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and tick requests into the delta-list sleep queue under
// bursty input and a stalling result side; a checker beside the block keeps
// a shadow list and compares every acknowledgement and wake-up.
// ----------------------------------------------------------------------------
module tb_top;
    import dlsq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int OWNER_WIDTH   = 8;
    localparam int RANDOM_ITEMS  = 245;    // on top of the directed opening
    localparam int PHASE_ITEMS   = 30;     // fill / drain phase length
    localparam int HUGE_LIMIT    = 2;      // extra sleepers with a random 32-bit sleep
    localparam int SETTLE_CYCLES = 80;     // longer than the worst insert latency
    localparam int CYCLE_LIMIT   = 200000;

    // result-side stall patterns
    typedef enum int {
        RX_OPEN,     // always ready
        RX_CHOPPY,   // ready half the time
        RX_SLOW      // ready a quarter of the time
    } t_rx_mode;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    t_in      req_data;
    logic     res_valid;
    logic     res_ready = 1'b0;
    t_out     res_data;

    int       fail_count;
    int       pending;
    int       ack_count;
    int       full_count;
    int       wake_count;
    int       insert_sent = 0;
    int       tick_sent   = 0;
    int       cycle_count;
    t_rx_mode rx_mode     = RX_OPEN;
    int       rx_left     = 0;

    delta_list_sleep_queue #(
        .CAPACITY    (CAPACITY),
        .OWNER_WIDTH (OWNER_WIDTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data)
    );

    dlsq_checker #(
        .CAPACITY    (CAPACITY),
        .OWNER_WIDTH (OWNER_WIDTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_ready   (req_ready),
        .i_in_data    (req_data),
        .i_out_valid  (res_valid),
        .i_out_ready  (res_ready),
        .i_out_data   (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ack_count  (ack_count),
        .o_full_count (full_count),
        .o_wake_count (wake_count)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: pick a stall pattern, hold it for a random stretch, then
    // pick again. RX_OPEN stretches give runs with no back-pressure at all.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   res_ready <= 1'b1;
            RX_CHOPPY: res_ready <= ($urandom_range(0, 1) == 1);
            default:   res_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic t_in insert_req(input logic [DELTA_W-1:0] ticks,
                                       input logic [ID_W-1:0]    owner);
        t_in r;
        r.cmd         = CMD_INSERT;
        r.sleep_ticks = ticks;
        r.owner_id    = owner;
        return r;
    endfunction

    // unused fields of a tick carry noise; the block must ignore them
    function automatic t_in tick_req();
        t_in r;
        r.cmd         = CMD_TICK;
        r.sleep_ticks = $urandom;
        r.owner_id    = ID_W'($urandom_range(0, 255));
        return r;
    endfunction

    // Present one request and return at the edge that accepts it. Valid is
    // left high so a following request goes out back to back.
    task automatic send(input t_in req);
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (req.cmd == CMD_INSERT)
            insert_sent++;
        else
            tick_sent++;
    endtask

    // gap between bursts
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop sending until every due answer has come back
    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d answers still due", cycle_count, pending);
        $display("delta_list_sleep_queue test failed");
        $finish;
    end

    initial begin
        logic [DELTA_W-1:0] ticks;
        logic [ID_W-1:0]    owner;
        logic [ID_W-1:0]    fill_owner;
        int                 burst_left;
        int                 huge_left;
        int                 pick;
        bit                 fill_phase;
        bit                 quiet_done;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // ---------------- directed opening ----------------
        // tick with nothing asleep: no answer
        send(tick_req());
        // zero-tick sleeper wakes on the very next tick
        send(insert_req('0, 8'hFF));
        send(tick_req());
        // equal deadlines: the later insert lands ahead, so owner 2 wakes
        // first; the first tick frees nothing, the second frees both
        send(insert_req(32'd2, 8'd1));
        send(insert_req(32'd2, 8'd2));
        send(tick_req());
        send(tick_req());
        // longest sleep possible: this entry stays for the whole run and
        // takes the follower reduction of the first insert in front of it
        send(insert_req('1, 8'h00));
        // fill the rest with one-tick sleepers; each goes to the head and zeroes
        // the delta of the one-tick sleeper behind it (the first trims the long one)
        fill_owner = 8'h10;
        for (int k = 0; k < CAPACITY - 1; k++) begin
            send(insert_req(32'd1, fill_owner));
            fill_owner++;
        end
        // queue full: refused, nothing changes
        send(insert_req(32'd7, 8'hAA));
        // one tick wakes every one-tick sleeper in a single answer train
        send(tick_req());
        // only the long sleeper left: tick with no wake-up
        send(tick_req());
        wait_quiet();

        // ---------------- random traffic ----------------
        // Alternating fill and drain phases keep the list moving between
        // empty and full. Sleeps are mostly short so entries keep expiring;
        // a few medium ones build longer lists, and at most HUGE_LIMIT more
        // sleeps take a random 32-bit tick count.
        burst_left = 0;
        huge_left  = HUGE_LIMIT;
        quiet_done = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 5) == 0)
                    burst_left = $urandom_range(20, 40);
                else
                    burst_left = $urandom_range(1, 8);
                // once, half way in, drain completely before going on
                if (!quiet_done && n >= RANDOM_ITEMS / 2) begin
                    quiet_done = 1'b1;
                    wait_quiet();
                end else begin
                    hold_off($urandom_range(0, 6));
                end
            end
            burst_left--;
            fill_phase = ((n / PHASE_ITEMS) % 2) == 0;
            if ($urandom_range(0, 99) < (fill_phase ? 75 : 30)) begin
                pick = $urandom_range(0, 99);
                if (pick < 3 && huge_left > 0) begin
                    ticks = $urandom;
                    huge_left--;
                end else if (pick < 15) begin
                    ticks = $urandom_range(20, 80);
                end else begin
                    ticks = $urandom_range(0, 8);
                end
                owner = ID_W'($urandom_range(0, 255));
                send(insert_req(ticks, owner));
            end else begin
                send(tick_req());
            end
        end

        // ---------------- wind-down ----------------
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d inserts, %0d ticks) in %0d cycles.",
                 insert_sent + tick_sent, insert_sent, tick_sent, cycle_count);
        $display("Checked %0d acknowledgements (%0d refused as full) and %0d wake-ups.",
                 ack_count, full_count, wake_count);
        if (fail_count == 0)
            $display("delta_list_sleep_queue test passed");
        else
            $display("delta_list_sleep_queue test failed");
        $finish;
    end

endmodule
